### hdl/ftarm_pkg.sv
package ftarm_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int ELAP_W       = 16;
  localparam int SUM_W        = ELAP_W + $clog2(WINDOW_DEPTH);
  localparam int FRAC_W       = 8;
  localparam int AVG_W        = 24;
  localparam int DVD_W        = SUM_W + FRAC_W;
  localparam int STEP_W       = $clog2(DVD_W + 1);
  localparam int RATE_W       = 16;
  localparam int ACC_W        = 17;
  localparam int LOCK_W       = 10;
  localparam int TIME_W       = 32;

  localparam logic [AVG_W-1:0] BAND_FIX  = AVG_W'(100 << FRAC_W);
  localparam logic [ACC_W-1:0] SECOND_MS = ACC_W'(1000);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STOP  = 2'd1,
    OP_START = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAP,
    S_CMP,
    S_SUB,
    S_ADD,
    S_DCHK,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/frame_time_averager_rate_meter.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | in_operation, in_now_ms
// out      | out_valid / out_stall| out_avg_frame_time, out_frame_rate,
//          |                      | out_is_stopped, out_total_ms
// cfg      | cfg_we               | cfg_lock_period_ms
//
// Stop, start and reset words go from idle straight to the done step; a tick
// runs the bit-serial divider that forms the average, unless stopped or empty.
// Reset is synchronous, active low; the window memory needs no clearing.
// One result word per input word; the result sits in an output register, so a
// stalled output holds the block in its final step, and in_stall stays high there.
module frame_time_averager_rate_meter
  import ftarm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AVG_W-1:0]  out_avg_frame_time,
  output logic [RATE_W-1:0] out_frame_rate,
  output logic              out_is_stopped,
  output logic [TIME_W-1:0] out_total_ms,
  input  logic              cfg_we,
  input  logic [LOCK_W-1:0] cfg_lock_period_ms
);

  state_t              state_r, state_nxt;
  logic [LOCK_W-1:0]   lock_r;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [TIME_W-1:0]   origin_r, origin_nxt;
  logic                paused_r, paused_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [AVG_W-1:0]    avg_r, avg_nxt;
  logic [RATE_W-1:0]   frames_r, frames_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [ELAP_W-1:0]   elap_r, elap_nxt;
  logic [AVG_W-1:0]    ref_r, ref_nxt;
  logic                band_r, band_nxt;
  logic                slow_r, slow_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]    out_avg_r, out_avg_nxt;
  logic [RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic                out_stop_r, out_stop_nxt;
  logic [TIME_W-1:0]   out_total_r, out_total_nxt;

  logic [ELAP_W-1:0]   mem [WINDOW_DEPTH];
  logic [ELAP_W-1:0]   rd_q_r;

  logic                div_start;
  div_stat_t           div_stat;
  logic [DVD_W-1:0]    div_q;

  logic [TIME_W-1:0]   delta;
  logic [AVG_W-1:0]    e16;
  logic [AVG_W-1:0]    diff;
  logic [RATE_W-1:0]   frames_inc;
  logic                accept;

  ftarm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {FRAC_W{1'b0}}}),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign accept     = in_valid && (state_r == S_IDLE);
  assign delta      = now_r - last_r;
  assign e16        = {elap_r, {FRAC_W{1'b0}}};
  assign diff       = (e16 >= ref_r) ? (e16 - ref_r) : (ref_r - e16);
  assign frames_inc = (slow_r && (frames_r != {RATE_W{1'b1}})) ? frames_r + 1'b1 : frames_r;

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    last_nxt      = last_r;
    origin_nxt    = origin_r;
    paused_nxt    = paused_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    avg_nxt       = avg_r;
    frames_nxt    = frames_r;
    acc_nxt       = acc_r;
    rate_nxt      = rate_r;
    elap_nxt      = elap_r;
    ref_nxt       = ref_r;
    band_nxt      = band_r;
    slow_nxt      = slow_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_avg_nxt   = out_avg_r;
    out_rate_nxt  = out_rate_r;
    out_stop_nxt  = out_stop_r;
    out_total_nxt = out_total_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt   = in_now_ms;
          state_nxt = S_DONE;
          case (op_t'(in_operation))
            OP_TICK: state_nxt = S_ELAP;
            OP_STOP: paused_nxt = 1'b1;
            OP_START: begin
              if (paused_r) begin
                last_nxt   = in_now_ms;
                paused_nxt = 1'b0;
              end
            end
            OP_RESET: begin
              origin_nxt = in_now_ms;
              last_nxt   = in_now_ms;
              paused_nxt = 1'b0;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ELAP: begin
        if (paused_r) begin
          avg_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          elap_nxt  = (|delta[TIME_W-1:ELAP_W]) ? {ELAP_W{1'b1}} : delta[ELAP_W-1:0];
          last_nxt  = now_r;
          ref_nxt   = (lock_r != '0) ? AVG_W'({lock_r, {FRAC_W{1'b0}}}) : avg_r;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        band_nxt  = diff < BAND_FIX;
        slow_nxt  = (lock_r != '0) && (e16 > ref_r);
        acc_nxt   = acc_r + ACC_W'(elap_r);
        state_nxt = S_SUB;
      end
      S_SUB: begin
        if (band_r && (cnt_r == CNT_W'(WINDOW_DEPTH))) begin
          sum_nxt = sum_r - SUM_W'(rd_q_r);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (band_r) begin
          sum_nxt  = sum_r + SUM_W'(elap_r);
          slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          if (cnt_r != CNT_W'(WINDOW_DEPTH)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (acc_r >= SECOND_MS) begin
          rate_nxt   = frames_inc;
          frames_nxt = '0;
          acc_nxt    = '0;
        end else begin
          frames_nxt = frames_inc;
        end
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (cnt_r == '0) begin
          avg_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          avg_nxt   = div_q[AVG_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_rate_nxt  = rate_r;
          out_stop_nxt  = paused_r;
          out_total_nxt = now_r - origin_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lock_r      <= '0;
      last_r      <= '0;
      origin_r    <= '0;
      paused_r    <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      avg_r       <= '0;
      frames_r    <= '0;
      acc_r       <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        lock_r <= cfg_lock_period_ms;
      end
      last_r      <= last_nxt;
      origin_r    <= origin_nxt;
      paused_r    <= paused_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      avg_r       <= avg_nxt;
      frames_r    <= frames_nxt;
      acc_r       <= acc_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r       <= now_nxt;
    elap_r      <= elap_nxt;
    ref_r       <= ref_nxt;
    band_r      <= band_nxt;
    slow_r      <= slow_nxt;
    out_avg_r   <= out_avg_nxt;
    out_rate_r  <= out_rate_nxt;
    out_stop_r  <= out_stop_nxt;
    out_total_r <= out_total_nxt;
  end

  // window ring
  always_ff @(posedge clk) begin
    if (state_r == S_ADD && band_r) begin
      mem[slot_r] <= elap_r;
    end
    rd_q_r <= mem[slot_r];
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_avg_frame_time = out_avg_r;
  assign out_frame_rate     = out_rate_r;
  assign out_is_stopped     = out_stop_r;
  assign out_total_ms       = out_total_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count above depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("nonzero sum with empty window");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide step");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (acc_r < SECOND_MS))
    else $error("accumulated ms not cleared at one second");

endmodule

### hdl/ftarm_div.sv
module ftarm_div
  import ftarm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### tb/sv/ftarm_checker.sv
`timescale 1ns / 1ps
module ftarm_checker
  import ftarm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [AVG_W-1:0]  out_avg_frame_time,
  input  logic [RATE_W-1:0] out_frame_rate,
  input  logic              out_is_stopped,
  input  logic [TIME_W-1:0] out_total_ms,
  input  logic              cfg_we,
  input  logic [LOCK_W-1:0] cfg_lock_period_ms,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic [RATE_W-1:0] rate;
    logic              stopped;
    logic [TIME_W-1:0] total;
  } frame_report_t;

  logic [LOCK_W-1:0] lock_ms;
  logic [TIME_W-1:0] last_ms;
  logic [TIME_W-1:0] origin_ms;
  logic              halted;
  logic [ELAP_W-1:0] window [WINDOW_DEPTH];
  logic [CNT_W-1:0]  fill;
  logic [SUM_W-1:0]  wsum;
  logic [SLOT_W-1:0] head;
  logic [AVG_W-1:0]  avg;
  logic [RATE_W-1:0] frames;
  logic [RATE_W-1:0] rate;
  logic [ACC_W-1:0]  acc_ms;

  frame_report_t expected_reports[$];
  int errs = 0;
  int queued_n = 0;

  assign mismatches  = errs;
  assign outstanding = queued_n;

  task automatic tick_frame(input logic [TIME_W-1:0] now);
    logic [31:0]       ref_fix;
    logic [31:0]       delta;
    logic [31:0]       e16;
    logic [31:0]       diff;
    logic [31:0]       quo;
    logic [ELAP_W-1:0] elapsed;
    ref_fix = (lock_ms != '0) ? (32'(lock_ms) << FRAC_W) : 32'(avg);
    if (halted) begin
      avg = '0;
    end else begin
      delta   = now - last_ms;
      elapsed = (delta > 32'hFFFF) ? 16'hFFFF : delta[ELAP_W-1:0];
      last_ms = now;
      e16     = 32'(elapsed) << FRAC_W;
      diff    = (e16 >= ref_fix) ? e16 - ref_fix : ref_fix - e16;
      if (diff < 32'(BAND_FIX)) begin
        if (fill >= CNT_W'(WINDOW_DEPTH)) wsum = wsum - SUM_W'(window[head]);
        window[head] = elapsed;
        wsum = wsum + SUM_W'(elapsed);
        head = (32'(head) == WINDOW_DEPTH - 1) ? '0 : head + 1'b1;
        if (fill < CNT_W'(WINDOW_DEPTH)) fill = fill + 1'b1;
      end
      if (lock_ms != '0 && e16 > ref_fix && frames != 16'hFFFF) frames = frames + 1'b1;
      acc_ms = acc_ms + ACC_W'(elapsed);
      if (acc_ms >= SECOND_MS) begin
        rate   = frames;
        frames = '0;
        acc_ms = '0;
      end
      if (fill != '0) begin
        quo = (32'(wsum) << FRAC_W) / 32'(fill);
        avg = quo[AVG_W-1:0];
      end else begin
        avg = '0;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    logic [TIME_W-1:0] now;
    if (!rst_n) begin
      lock_ms   = '0;
      last_ms   = '0;
      origin_ms = '0;
      halted    = 1'b0;
      fill      = '0;
      wsum      = '0;
      head      = '0;
      avg       = '0;
      frames    = '0;
      rate      = '0;
      acc_ms    = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) lock_ms = cfg_lock_period_ms;

      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected: avg %0h rate %0h stopped %0b total %0h",
                   $time, out_avg_frame_time, out_frame_rate, out_is_stopped, out_total_ms);
        end else begin
          want = expected_reports.pop_front();
          check_field("avg_frame_time", 32'(want.avg), 32'(out_avg_frame_time));
          check_field("frame_rate", 32'(want.rate), 32'(out_frame_rate));
          check_field("is_stopped", 32'(want.stopped), 32'(out_is_stopped));
          check_field("total_ms", want.total, out_total_ms);
        end
      end

      if (in_valid && !in_stall) begin
        now = in_now_ms;
        case (op_t'(in_operation))
          OP_TICK: tick_frame(now);
          OP_STOP: halted = 1'b1;
          OP_START: begin
            if (halted) begin
              last_ms = now;
              halted  = 1'b0;
            end
          end
          OP_RESET: begin
            origin_ms = now;
            last_ms   = now;
            halted    = 1'b0;
          end
          default: ;
        endcase
        want.avg     = avg;
        want.rate    = rate;
        want.stopped = halted;
        want.total   = now - origin_ms;
        expected_reports.push_back(want);
      end
    end
    queued_n <= expected_reports.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb
  import ftarm_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 135;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_operation;
  logic [TIME_W-1:0] in_now_ms;
  logic              out_valid;
  logic              out_stall;
  logic [AVG_W-1:0]  out_avg_frame_time;
  logic [RATE_W-1:0] out_frame_rate;
  logic              out_is_stopped;
  logic [TIME_W-1:0] out_total_ms;
  logic              cfg_we;
  logic [LOCK_W-1:0] cfg_lock_period_ms;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic [TIME_W-1:0] now_ms;
  int lock_settings [9] = '{0, 16, 1000, 0, 1023, 33, 1, 0, 500};

  frame_time_averager_rate_meter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_frame_time (out_avg_frame_time),
    .out_frame_rate     (out_frame_rate),
    .out_is_stopped     (out_is_stopped),
    .out_total_ms       (out_total_ms),
    .cfg_we             (cfg_we),
    .cfg_lock_period_ms (cfg_lock_period_ms)
  );

  ftarm_checker CHK (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_frame_time (out_avg_frame_time),
    .out_frame_rate     (out_frame_rate),
    .out_is_stopped     (out_is_stopped),
    .out_total_ms       (out_total_ms),
    .cfg_we             (cfg_we),
    .cfg_lock_period_ms (cfg_lock_period_ms),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_word(input op_t op, input logic [TIME_W-1:0] t);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_now_ms    <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic tick_after(input logic [TIME_W-1:0] dt);
    now_ms = now_ms + dt;
    send_word(OP_TICK, now_ms);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_lock(input logic [LOCK_W-1:0] period);
    drain();
    repeat (2) @(posedge clk);
    cfg_we             <= 1'b1;
    cfg_lock_period_ms <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int lock;
    int nominal;
    int spread;
    int d;
    int pick;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_operation       <= OP_TICK;
    in_now_ms          <= '0;
    cfg_we             <= 1'b0;
    cfg_lock_period_ms <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: band edges, stop/start rules, wrap and saturation
    now_ms = '0;
    send_word(OP_TICK, now_ms);
    tick_after(16);
    tick_after(33);
    tick_after(17);
    tick_after(500);
    tick_after(40);
    send_word(OP_STOP, now_ms + 3);
    send_word(OP_STOP, now_ms + 4);
    send_word(OP_TICK, now_ms + 9);
    send_word(OP_START, now_ms + 12);
    send_word(OP_START, now_ms + 30);
    now_ms = now_ms + 12;
    tick_after(20);
    now_ms = 32'hFFFF_FF00;
    send_word(OP_RESET, now_ms);
    tick_after(32'h110);
    tick_after(70000);
    send_word(OP_RESET, 32'h0000_0005);
    now_ms = 32'h0000_0002;
    send_word(OP_TICK, now_ms);
    now_ms = 32'hFFFF_FFFF;
    send_word(OP_RESET, now_ms);
    tick_after(1);
    write_lock(16);
    tick_after(16);
    tick_after(17);
    tick_after(115);
    tick_after(116);
    tick_after(900);

    for (int p = 0; p < 9; p++) begin
      lock = (p == 8) ? $urandom_range(2, 999) : lock_settings[p];
      case (p / 3)
        0: begin
          gap_pct   = 10;
          stall_pct = 49;
        end
        1: begin
          gap_pct   = 49;
          stall_pct = 10;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      write_lock(LOCK_W'(lock));
      nominal = (lock != 0) ? lock : $urandom_range(1, 90);
      spread  = (lock != 0) ? 110 : 30;
      // a tick while stopped clears the average so the free-running band restarts
      if (lock == 0) begin
        send_word(OP_STOP, now_ms);
        send_word(OP_TICK, now_ms + 1);
        send_word(OP_START, now_ms + 2);
        now_ms = now_ms + 2;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          if ($urandom_range(9) == 0) begin
            d = nominal + $urandom_range(1);
          end else begin
            d = nominal + $urandom_range(0, 2 * spread) - spread;
          end
          if (d < 0) d = 0;
          tick_after(TIME_W'(d));
        end else if (pick < 88) begin
          send_word(OP_STOP, now_ms + $urandom_range(0, 50));
          if ($urandom_range(1)) send_word(OP_STOP, now_ms + $urandom_range(0, 50));
          if ($urandom_range(1)) send_word(OP_TICK, now_ms + $urandom_range(0, 500));
          now_ms = now_ms + $urandom_range(0, 800);
          send_word(OP_START, now_ms);
          if ($urandom_range(1)) send_word(OP_START, now_ms + $urandom_range(0, 50));
        end else if (pick < 91) begin
          now_ms = $urandom();
          send_word(OP_RESET, now_ms);
        end else if (pick < 94) begin
          now_ms = $urandom();
          send_word(OP_TICK, now_ms);
        end else if (pick < 96) begin
          send_word(OP_START, now_ms + $urandom_range(0, 5000));
        end else if (pick < 98) begin
          tick_after($urandom_range(1) ? 0 : $urandom_range(65536, 200000));
        end else if (pick < 99) begin
          drain();
        end else begin
          tick_after($urandom_range(0, 3000));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
